### rtl/core/stks_pkg.sv
// Shared types and codes for the sorted table key search block.
package stks_pkg;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_FULL     = 3'd1,
		ST_FOUND    = 3'd2,
		ST_MISSING  = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SORT_RD,
		S_SORT_HOLD,
		S_SORT_CMP,
		S_SORT_PLACE,
		S_PROBE,
		S_SCMP
	} state_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_SLOT_M1,
		RD_SLOT_M2,
		RD_MID
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_ITEM,
		WR_DATA,
		WR_HOLD
	} wr_sel_t;

	typedef struct packed {
		logic [15:0] key;
		logic [31:0] price;
		logic [7:0]  tag;
	} rec_t;

	typedef struct packed {
		logic    item_load;
		logic    cnt_inc;
		logic    cnt_clr;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    i_init;
		logic    i_inc;
		logic    slot_from_i;
		logic    slot_dec;
		logic    hold_load;
		logic    srch_init;
		logic    low_upd;
		logic    hix_upd;
		logic    res_load;
		status_t res_code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       out_free;
		logic       full;
		logic       i_done;
		logic       slot_one;
		logic       key_gt;
		logic       range_empty;
		logic       key_eq;
		logic       key_lt;
	} sts_t;

endpackage

### rtl/core/stks_in_if.sv
// Input channel: one command word per handshake.
interface stks_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] room_key;
	logic [31:0] price;
	logic [7:0]  payload_tag;

	modport source(output valid, output action, output room_key, output price,
		output payload_tag, input ready);
	modport sink(input valid, input action, input room_key, input price,
		input payload_tag, output ready);
endinterface

### rtl/core/stks_out_if.sv
// Result channel: one result word per handshake.
interface stks_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  position;
	logic [31:0] found_price;
	logic [7:0]  found_tag;

	modport source(output valid, output status, output position, output found_price,
		output found_tag, input ready);
	modport sink(input valid, input status, input position, input found_price,
		input found_tag, output ready);
endinterface

### rtl/core/sorted_table_key_search.sv
// Top level of the sorted record table with key search.
//
//   channel  dir  fields                                   handshake
//   item     in   action, room_key, price, payload_tag     valid/ready
//   result   out  status, position, found_price, found_tag valid/ready
//
// Append, clear and unused codes are answered from the dispatch state, which
// loads the result register once it is free. A search first runs an insertion
// sort over the stored records and then a binary search; its duration grows with
// the record count and the number of record moves, and is set by the single read port
// of the record RAM and its registered read.
// Reset clears the entry count, the result valid flag and the controller; record contents are kept.
// One item is worked on at a time; a finished result waits in the output
// register while the next item is taken, and a stalled result holds the block.
module sorted_table_key_search #(
	parameter int TABLE_DEPTH = 64
) (
	input logic      clk,
	input logic      arst_n,
	stks_in_if.sink  item,
	stks_out_if.source result
);

	stks_pkg::cmd_t cmd;
	stks_pkg::sts_t sts;

	stks_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item.valid),
		.in_ready(item.ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	stks_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (item.action),
		.room_key    (item.room_key),
		.price       (item.price),
		.payload_tag (item.payload_tag),
		.cmd         (cmd),
		.sts         (sts),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.res_status  (result.status),
		.res_position(result.position),
		.res_price   (result.found_price),
		.res_tag     (result.found_tag)
	);

endmodule

### rtl/core/stks_ram.sv
// Generic single write port, single read port RAM with registered read.
module stks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/core/stks_datapath.sv
// Datapath: record RAM, sort and search indices, item and result registers.
module stks_datapath #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         action,
	input  logic [15:0]        room_key,
	input  logic [31:0]        price,
	input  logic [7:0]         payload_tag,
	input  stks_pkg::cmd_t     cmd,
	output stks_pkg::sts_t     sts,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         res_status,
	output logic [5:0]         res_position,
	output logic [31:0]        res_price,
	output logic [7:0]         res_tag
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [1:0]      act_q;
	logic [15:0]     key_q;
	logic [31:0]     price_q;
	logic [7:0]      tag_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   i_q;
	logic [AW-1:0]   slot_q;
	logic [CW-1:0]   low_q;
	logic [CW-1:0]   hix_q;
	stks_pkg::rec_t  hold_q;
	logic            res_valid_q;
	logic [2:0]      res_status_q;
	logic [5:0]      res_position_q;
	logic [31:0]     res_price_q;
	logic [7:0]      res_tag_q;

	logic [CW-1:0]   span;
	logic [CW-1:0]   mid;
	logic            out_free;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	stks_pkg::rec_t  wr_data;
	stks_pkg::rec_t  rd_data;

	// search window is [low, hix); mid matches low + (high - low) / 2 with high = hix - 1
	assign span     = hix_q - low_q - CW'(1);
	assign mid      = low_q + (span >> 1);
	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		case (cmd.rd_sel)
			stks_pkg::RD_I:       rd_addr = i_q[AW-1:0];
			stks_pkg::RD_SLOT_M1: rd_addr = slot_q - AW'(1);
			stks_pkg::RD_SLOT_M2: rd_addr = slot_q - AW'(2);
			stks_pkg::RD_MID:     rd_addr = mid[AW-1:0];
			default:              rd_addr = mid[AW-1:0];
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			stks_pkg::WR_ITEM: begin
				wr_addr = cnt_q[AW-1:0];
				wr_data = '{key: key_q, price: price_q, tag: tag_q};
			end
			stks_pkg::WR_DATA: begin
				wr_addr = slot_q;
				wr_data = rd_data;
			end
			stks_pkg::WR_HOLD: begin
				wr_addr = slot_q;
				wr_data = hold_q;
			end
			default: begin
				wr_addr = slot_q;
				wr_data = hold_q;
			end
		endcase
	end

	stks_ram #(
		.WIDTH($bits(stks_pkg::rec_t)),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			act_q   <= action;
			key_q   <= room_key;
			price_q <= price;
			tag_q   <= payload_tag;
		end
		if (cmd.i_init) begin
			i_q <= CW'(1);
		end else if (cmd.i_inc) begin
			i_q <= i_q + CW'(1);
		end
		if (cmd.slot_from_i) begin
			slot_q <= i_q[AW-1:0];
		end else if (cmd.slot_dec) begin
			slot_q <= slot_q - AW'(1);
		end
		if (cmd.hold_load) begin
			hold_q <= rd_data;
		end
		if (cmd.srch_init) begin
			low_q <= '0;
			hix_q <= cnt_q;
		end else if (cmd.low_upd) begin
			low_q <= mid + CW'(1);
		end else if (cmd.hix_upd) begin
			hix_q <= mid;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			if (cmd.res_code == stks_pkg::ST_FOUND) begin
				res_position_q <= 6'(mid);
				res_price_q    <= rd_data.price;
				res_tag_q      <= rd_data.tag;
			end else begin
				res_position_q <= '0;
				res_price_q    <= '0;
				res_tag_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.act         = act_q;
	assign sts.out_free    = out_free;
	assign sts.full        = (cnt_q == CW'(TABLE_DEPTH));
	assign sts.i_done      = (i_q >= cnt_q);
	assign sts.slot_one    = (slot_q == AW'(1));
	assign sts.key_gt      = (rd_data.key > hold_q.key);
	assign sts.range_empty = (low_q >= hix_q);
	assign sts.key_eq      = (rd_data.key == key_q);
	assign sts.key_lt      = (rd_data.key < key_q);

	assign res_valid    = res_valid_q;
	assign res_status   = res_status_q;
	assign res_position = res_position_q;
	assign res_price    = res_price_q;
	assign res_tag      = res_tag_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");
	a_res_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result loaded over an untaken word");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_sel == stks_pkg::WR_ITEM) |-> !sts.full)
		else $error("append written into a full table");
	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> res_valid_q)
		else $error("loaded result not offered");
`endif

endmodule

### rtl/core/stks_ctrl.sv
// Controller: sequences append, clear, insertion sort and binary search.
module stks_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output stks_pkg::cmd_t cmd,
	input  stks_pkg::sts_t sts
);

	stks_pkg::state_t state_q;
	stks_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stks_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stks_pkg::S_IDLE: begin
				if (in_valid) state_d = stks_pkg::S_DISPATCH;
			end
			stks_pkg::S_DISPATCH: begin
				if (sts.act == stks_pkg::ACT_SEARCH) begin
					state_d = stks_pkg::S_SORT_RD;
				end else if (sts.out_free) begin
					state_d = stks_pkg::S_IDLE;
				end
			end
			stks_pkg::S_SORT_RD: begin
				state_d = sts.i_done ? stks_pkg::S_PROBE : stks_pkg::S_SORT_HOLD;
			end
			stks_pkg::S_SORT_HOLD: state_d = stks_pkg::S_SORT_CMP;
			stks_pkg::S_SORT_CMP: begin
				if (!sts.key_gt) begin
					state_d = stks_pkg::S_SORT_RD;
				end else if (sts.slot_one) begin
					state_d = stks_pkg::S_SORT_PLACE;
				end
			end
			stks_pkg::S_SORT_PLACE: state_d = stks_pkg::S_SORT_RD;
			stks_pkg::S_PROBE: begin
				if (!sts.range_empty) begin
					state_d = stks_pkg::S_SCMP;
				end else if (sts.out_free) begin
					state_d = stks_pkg::S_IDLE;
				end
			end
			stks_pkg::S_SCMP: begin
				if (!sts.key_eq) begin
					state_d = stks_pkg::S_PROBE;
				end else if (sts.out_free) begin
					state_d = stks_pkg::S_IDLE;
				end
			end
			default: state_d = stks_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = stks_pkg::RD_MID;
		cmd.wr_sel   = stks_pkg::WR_ITEM;
		cmd.res_code = stks_pkg::ST_MISSING;
		in_ready     = 1'b0;
		case (state_q)
			stks_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				cmd.item_load = in_valid;
			end
			stks_pkg::S_DISPATCH: begin
				case (sts.act)
					stks_pkg::ACT_APPEND: begin
						if (sts.out_free) begin
							cmd.res_load = 1'b1;
							if (sts.full) begin
								cmd.res_code = stks_pkg::ST_FULL;
							end else begin
								cmd.res_code = stks_pkg::ST_APPENDED;
								cmd.wr_en    = 1'b1;
								cmd.cnt_inc  = 1'b1;
							end
						end
					end
					stks_pkg::ACT_SEARCH: cmd.i_init = 1'b1;
					stks_pkg::ACT_CLEAR: begin
						if (sts.out_free) begin
							cmd.res_load = 1'b1;
							cmd.res_code = stks_pkg::ST_CLEARED;
							cmd.cnt_clr  = 1'b1;
						end
					end
					default: cmd.res_load = sts.out_free;
				endcase
			end
			stks_pkg::S_SORT_RD: begin
				if (sts.i_done) begin
					cmd.srch_init = 1'b1;
				end else begin
					cmd.rd_sel      = stks_pkg::RD_I;
					cmd.slot_from_i = 1'b1;
				end
			end
			stks_pkg::S_SORT_HOLD: begin
				cmd.hold_load = 1'b1;
				cmd.rd_sel    = stks_pkg::RD_SLOT_M1;
			end
			stks_pkg::S_SORT_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.key_gt) begin
					// shift the larger record up and fetch the next one down
					cmd.wr_sel   = stks_pkg::WR_DATA;
					cmd.slot_dec = 1'b1;
					cmd.rd_sel   = stks_pkg::RD_SLOT_M2;
				end else begin
					cmd.wr_sel = stks_pkg::WR_HOLD;
					cmd.i_inc  = 1'b1;
				end
			end
			stks_pkg::S_SORT_PLACE: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = stks_pkg::WR_HOLD;
				cmd.i_inc  = 1'b1;
			end
			stks_pkg::S_PROBE: begin
				if (sts.range_empty) begin
					cmd.res_load = sts.out_free;
				end
			end
			stks_pkg::S_SCMP: begin
				if (sts.key_eq) begin
					cmd.res_load = sts.out_free;
					cmd.res_code = stks_pkg::ST_FOUND;
				end else if (sts.key_lt) begin
					cmd.low_upd = 1'b1;
				end else begin
					cmd.hix_upd = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule
